// ===== rtl/core/ipr_pkg.sv =====
// Shared types, constants and the CRC byte step of the instruction packet receiver.
package ipr_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int IDX_W     = 10;
  localparam int TIMEOUT_W = 20;
  localparam int GAP_W     = 21;
  localparam int CRC_W     = 16;
  localparam int LEN_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Parameter defaults
  localparam int MAX_PARAM_LEN_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // Protocol constants
  localparam logic [BYTE_W-1:0]    HDR_FF       = 8'hFF;
  localparam logic [BYTE_W-1:0]    HDR_FD       = 8'hFD;
  localparam logic [CRC_W-1:0]     CRC_POLY     = 16'h8005;
  localparam logic [LEN_W-1:0]     LEN_OVERHEAD = 16'd3;
  localparam logic [GAP_W-1:0]     GAP_MAX      = '1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 20'd100000;
  localparam logic [BYTE_W-1:0]    STATUS_RST   = 8'd85;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_STATUS  = 2'd1
  } cfg_reg_e;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PARAM = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2
  } kind_e;

  // Parser phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RESERVED = 4'd1,
    PH_ID       = 4'd2,
    PH_LEN_L    = 4'd3,
    PH_LEN_H    = 4'd4,
    PH_INST     = 4'd5,
    PH_PARAM    = 4'd6,
    PH_CRC_L    = 4'd7,
    PH_CRC_H    = 4'd8
  } phase_e;

  // Configuration seen by the back end
  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [BYTE_W-1:0]    status_inst_code;
  } cfg_t;

  // Classified request carried from front to back
  typedef struct packed {
    logic              is_tick;
    logic              is_fd;
    logic [BYTE_W-1:0] data;
  } item_t;

  // One byte of CRC-16, MSB first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC after the header FF FF FD
  localparam logic [CRC_W-1:0] HDR_CRC =
    crc_byte(crc_byte(crc_byte(16'h0000, HDR_FF), HDR_FF), HDR_FD);

endpackage

// ===== rtl/core/ipr_intf.sv =====
// Channel interfaces of the instruction packet receiver: input, result and configuration.
interface ipr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface ipr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [9:0] param_index;
  logic [7:0] device_id;
  logic [7:0] instruction;
  logic [9:0] param_count;

  modport source (output valid, output kind, output data_byte, output param_index,
                  output device_id, output instruction, output param_count,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input param_index,
                input device_id, input instruction, input param_count,
                output ready);
endinterface

interface ipr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ipr_fifo.sv =====
// Short request queue between the front and back ends of the packet receiver.
module ipr_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     push_data_i,
  output logic full_o,
  input  logic pop_i,
  output T     pop_data_o,
  output logic valid_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  T                 mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem[rd_ptr_q];

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/ipr_front.sv =====
// Front end: accept serial bytes and ticks, classify them and queue them for the parser.
module ipr_front (
  ipr_in_if.sink         rx_i,
  input  logic           queue_full_i,
  output logic           push_o,
  output ipr_pkg::item_t item_o
);
  import ipr_pkg::*;

  // Accept while the queue has room
  assign rx_i.ready = !queue_full_i;
  assign push_o     = rx_i.valid && !queue_full_i;

  // Tag ticks and the header marker byte
  always_comb begin
    item_o.is_tick = rx_i.cmd;
    item_o.data    = rx_i.rx_byte;
    item_o.is_fd   = (rx_i.rx_byte == HDR_FD);
  end

endmodule

// ===== rtl/core/ipr_back.sv =====
// Back end: frame parser, CRC check, unstuffing and the result register.
module ipr_back #(
  parameter int MAX_PARAM_LEN = ipr_pkg::MAX_PARAM_LEN_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ipr_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  input  ipr_pkg::item_t item_i,
  output logic           pop_o,
  ipr_out_if.source      res_o
);
  import ipr_pkg::*;

  localparam int PW = $clog2(MAX_PARAM_LEN);

  // Parser state
  phase_e            phase_q, phase_d, eff_phase;
  logic [1:0]        fill_q, fill_d, eff_fill;
  logic [BYTE_W-1:0] win0_q, win0_d, win1_q, win1_d;
  logic [CRC_W-1:0]  crc_q, crc_d, crc_next;
  logic [BYTE_W-1:0] crc_lo_q, crc_lo_d;
  logic [BYTE_W-1:0] len_lo_q, len_lo_d;
  logic [PW-1:0]     exp_q, exp_d;
  logic [PW-1:0]     rcv_q, rcv_d, rcv_inc;
  logic [PW-1:0]     emit_q, emit_d, emit_inc;
  logic [BYTE_W-1:0] id_q, id_d, inst_q, inst_d;
  logic [BYTE_W-1:0] hist0_q, hist0_d, hist1_q, hist1_d;
  logic [1:0]        hcnt_q, hcnt_d;
  logic              drop_q, drop_d;
  logic [GAP_W-1:0]  gap_q, gap_d;

  // Result register
  logic              out_vld_q;
  logic [KIND_W-1:0] out_kind_q, res_kind;
  logic [BYTE_W-1:0] out_data_q, res_data;
  logic [IDX_W-1:0]  out_idx_q, res_idx;
  logic [BYTE_W-1:0] out_id_q, out_inst_q;
  logic [IDX_W-1:0]  out_cnt_q, res_cnt;
  logic              res_vld;

  logic                advance, timed_out, hdr_hit, stuff_hit, too_big;
  logic [LEN_W-1:0]    len_full, len_params;
  logic [PW+IDX_W-1:0] idx_ext, cnt_ext, cnt_inc_ext;
  logic [BYTE_W-1:0]   b;

  assign b       = item_i.data;
  assign advance = item_valid_i && (!out_vld_q || res_o.ready);
  assign pop_o   = advance;

  // Timeout drops the parser back to the hunt before the byte is handled
  assign timed_out = !item_i.is_tick && (gap_q > {1'b0, cfg_i.timeout_ticks});
  assign eff_phase = timed_out ? PH_IDLE : phase_q;
  assign eff_fill  = timed_out ? 2'd0 : fill_q;

  assign crc_next   = crc_byte(crc_q, b);
  assign hdr_hit    = (win0_q == HDR_FF) && (win1_q == HDR_FF) && item_i.is_fd;
  assign stuff_hit  = (hcnt_q == 2'd2) && (hist0_q == HDR_FF) && (hist1_q == HDR_FF) &&
                      item_i.is_fd;
  assign len_full   = {b, len_lo_q};
  assign len_params = (len_full > LEN_OVERHEAD) ? len_full - LEN_OVERHEAD : '0;
  assign too_big    = (32'(len_params) >= 32'(MAX_PARAM_LEN));
  assign rcv_inc    = rcv_q + 1'b1;
  assign emit_inc   = emit_q + 1'b1;

  // Low ten bits of the counters at any counter width
  assign idx_ext     = {{IDX_W{1'b0}}, emit_q};
  assign cnt_inc_ext = {{IDX_W{1'b0}}, emit_inc};
  assign cnt_ext     = {{IDX_W{1'b0}}, emit_q};

  // Next parser phase
  always_comb begin
    phase_d = phase_q;
    if (!item_i.is_tick) begin
      case (eff_phase)
        PH_IDLE: begin
          phase_d = (eff_fill >= 2'd2 && hdr_hit) ? PH_RESERVED : PH_IDLE;
        end
        PH_RESERVED: phase_d = item_i.is_fd ? PH_IDLE : PH_ID;
        PH_ID:       phase_d = PH_LEN_L;
        PH_LEN_L:    phase_d = PH_LEN_H;
        PH_LEN_H:    phase_d = too_big ? PH_IDLE : PH_INST;
        PH_INST: begin
          if (b == cfg_i.status_inst_code) begin
            phase_d = PH_IDLE;
          end else begin
            phase_d = (exp_q != '0) ? PH_PARAM : PH_CRC_L;
          end
        end
        PH_PARAM:    phase_d = (rcv_inc >= exp_q) ? PH_CRC_L : PH_PARAM;
        PH_CRC_L:    phase_d = PH_CRC_H;
        PH_CRC_H:    phase_d = PH_IDLE;
        default:     phase_d = PH_IDLE;
      endcase
    end
  end

  // Datapath and result for the current request
  always_comb begin
    fill_d   = fill_q;
    win0_d   = win0_q;
    win1_d   = win1_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    len_lo_d = len_lo_q;
    exp_d    = exp_q;
    rcv_d    = rcv_q;
    emit_d   = emit_q;
    id_d     = id_q;
    inst_d   = inst_q;
    hist0_d  = hist0_q;
    hist1_d  = hist1_q;
    hcnt_d   = hcnt_q;
    drop_d   = drop_q;
    gap_d    = gap_q;
    res_vld  = 1'b0;
    res_kind = KIND_PARAM;
    res_data = '0;
    res_idx  = '0;
    res_cnt  = cnt_ext[IDX_W-1:0];

    if (item_i.is_tick) begin
      // Count ticks, saturating
      if (gap_q != GAP_MAX) begin
        gap_d = gap_q + 1'b1;
      end
    end else begin
      fill_d = eff_fill;
      gap_d  = timed_out ? '0 : gap_q;
      case (eff_phase)
        PH_IDLE: begin
          gap_d = '0;
          if (eff_fill >= 2'd2) begin
            if (hdr_hit) begin
              fill_d = 2'd0;
              crc_d  = HDR_CRC;
            end else begin
              win0_d = win1_q;
              win1_d = b;
            end
          end else begin
            if (eff_fill[0]) begin
              win1_d = b;
            end else begin
              win0_d = b;
            end
            fill_d = eff_fill + 1'b1;
          end
        end
        PH_RESERVED: crc_d = crc_next;
        PH_ID: begin
          id_d  = b;
          crc_d = crc_next;
        end
        PH_LEN_L: begin
          len_lo_d = b;
          crc_d    = crc_next;
        end
        PH_LEN_H: begin
          exp_d = too_big ? '0 : len_params[PW-1:0];
          crc_d = crc_next;
        end
        PH_INST: begin
          inst_d  = b;
          rcv_d   = '0;
          emit_d  = '0;
          drop_d  = 1'b0;
          hist0_d = '0;
          hist1_d = b;
          hcnt_d  = 2'd1;
          crc_d   = crc_next;
        end
        PH_PARAM: begin
          crc_d = crc_next;
          rcv_d = rcv_inc;
          if (drop_q) begin
            // Drop the stuffing byte
            drop_d = 1'b0;
          end else begin
            drop_d   = stuff_hit;
            hist0_d  = hist1_q;
            hist1_d  = b;
            hcnt_d   = (hcnt_q == 2'd2) ? 2'd2 : hcnt_q + 1'b1;
            emit_d   = emit_inc;
            res_vld  = 1'b1;
            res_kind = KIND_PARAM;
            res_data = b;
            res_idx  = idx_ext[IDX_W-1:0];
            res_cnt  = cnt_inc_ext[IDX_W-1:0];
          end
        end
        PH_CRC_L: crc_lo_d = b;
        PH_CRC_H: begin
          res_vld  = 1'b1;
          res_kind = ({b, crc_lo_q} == crc_q) ? KIND_GOOD : KIND_BAD;
        end
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      fill_q    <= '0;
      win0_q    <= '0;
      win1_q    <= '0;
      crc_q     <= '0;
      crc_lo_q  <= '0;
      len_lo_q  <= '0;
      exp_q     <= '0;
      rcv_q     <= '0;
      emit_q    <= '0;
      id_q      <= '0;
      inst_q    <= '0;
      hist0_q   <= '0;
      hist1_q   <= '0;
      hcnt_q    <= '0;
      drop_q    <= 1'b0;
      gap_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        phase_q   <= phase_d;
        fill_q    <= fill_d;
        win0_q    <= win0_d;
        win1_q    <= win1_d;
        crc_q     <= crc_d;
        crc_lo_q  <= crc_lo_d;
        len_lo_q  <= len_lo_d;
        exp_q     <= exp_d;
        rcv_q     <= rcv_d;
        emit_q    <= emit_d;
        id_q      <= id_d;
        inst_q    <= inst_d;
        hist0_q   <= hist0_d;
        hist1_q   <= hist1_d;
        hcnt_q    <= hcnt_d;
        drop_q    <= drop_d;
        gap_q     <= gap_d;
        out_vld_q <= res_vld;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_kind_q <= res_kind;
      out_data_q <= res_data;
      out_idx_q  <= res_idx;
      out_id_q   <= id_d;
      out_inst_q <= inst_d;
      out_cnt_q  <= res_cnt;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.kind        = out_kind_q;
  assign res_o.data_byte   = out_data_q;
  assign res_o.param_index = out_idx_q;
  assign res_o.device_id   = out_id_q;
  assign res_o.instruction = out_inst_q;
  assign res_o.param_count = out_cnt_q;

endmodule

// ===== rtl/core/instruction_packet_receiver_top.sv =====
// Top level of the instruction packet receiver: configuration registers, front, queue and back.
// The receiver takes one request per cycle, either a serial byte (cmd 0) or a time tick
// (cmd 1), and sustains one request per clock while the result output is not stalled. An
// accepted byte is written into the request queue, then taken through the parser step, which
// holds the frame state machine and a single CRC-16 byte update (polynomial 0x8005, MSB
// first), into the result register. A result waiting on the output does not stop intake
// until the queue of QUEUE_DEPTH requests fills. Each packet yields one parameter result per
// unstuffed parameter byte and one final result with the CRC verdict; a packet with the
// status instruction code yields none, and one cut off by the timeout yields no verdict.
// Ticks, header bytes and rejected frames yield none. Configuration writes are always taken
// in the cycle they are offered and should be made while the receiver is idle.
module instruction_packet_receiver_top #(
  parameter int MAX_PARAM_LEN = ipr_pkg::MAX_PARAM_LEN_DEF,
  parameter int QUEUE_DEPTH   = ipr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ipr_in_if.sink    rx_i,
  ipr_out_if.source res_o,
  ipr_cfg_if.sink   cfg_i
);
  import ipr_pkg::*;

  cfg_t  cfg_q;
  logic  cfg_we;
  logic  push, queue_full, pop, queue_valid;
  item_t push_item, pop_item;

  // Configuration writes are always taken
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks    <= TIMEOUT_RST;
      cfg_q.status_inst_code <= STATUS_RST;
    end else if (cfg_we) begin
      if (cfg_i.index == CFG_TIMEOUT) begin
        cfg_q.timeout_ticks <= cfg_i.data;
      end else if (cfg_i.index == CFG_STATUS) begin
        cfg_q.status_inst_code <= cfg_i.data[BYTE_W-1:0];
      end
    end
  end

  ipr_front u_front (
    .rx_i         (rx_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (push_item)
  );

  ipr_fifo #(
    .T     (item_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .full_o      (queue_full),
    .pop_i       (pop),
    .pop_data_o  (pop_item),
    .valid_o     (queue_valid)
  );

  ipr_back #(
    .MAX_PARAM_LEN (MAX_PARAM_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (queue_valid),
    .item_i       (pop_item),
    .pop_o        (pop),
    .res_o        (res_o)
  );

endmodule

// ===== rtl/core/ipr_checker.sv =====
// Port-level checks of the instruction packet receiver, bound to its top level.
module ipr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] res_kind_i,
  input logic [7:0] res_data_i,
  input logic [9:0] res_index_i,
  input logic [9:0] res_count_i
);
  import ipr_pkg::*;

  // A stalled result stays offered
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // Only defined kinds leave the receiver
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_kind_i == KIND_PARAM || res_kind_i == KIND_GOOD ||
                     res_kind_i == KIND_BAD))
    else $error("undefined result kind");

  // Packet verdicts carry no parameter byte
  a_verdict_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_kind_i != KIND_PARAM |-> (res_data_i == 8'h00 && res_index_i == 10'd0))
    else $error("verdict carries parameter data");

  // A parameter byte is counted along with its position
  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_kind_i == KIND_PARAM |-> res_count_i == res_index_i + 10'd1)
    else $error("parameter count out of step with index");

endmodule

bind instruction_packet_receiver_top ipr_checker u_ipr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_kind_i  (res_o.kind),
  .res_data_i  (res_o.data_byte),
  .res_index_i (res_o.param_index),
  .res_count_i (res_o.param_count)
);
